@@ src/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

  // control flags a sorter cell shows to its neighbors
  typedef struct packed {
    logic valid;  // cell holds a sample
    logic del;    // cell holds the oldest sample, the one that leaves the chain
    logic dl;     // cell sits right of the leaving sample
    logic gt;     // cell value above the incoming sample
  } link_t;

  localparam link_t LINK_HEAD = '{valid: 1'b1, del: 1'b0, dl: 1'b0, gt: 1'b0};
  localparam link_t LINK_NONE = '{valid: 1'b0, del: 1'b0, dl: 1'b0, gt: 1'b0};

endpackage

@@ src/swm_in_if.sv @@
// ----------------------------------------------------------------------------
// swm_in_if
// Sample input channel: valid/ready handshake with sample and end marker.
// ----------------------------------------------------------------------------
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    end_of_stream;

  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

@@ src/swm_out_if.sv @@
// ----------------------------------------------------------------------------
// swm_out_if
// Median output channel: valid/ready handshake with the median value.
// ----------------------------------------------------------------------------
interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

@@ src/sliding_window_median_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_core
// Streaming lower-median filter over the last k signed samples (window_size
// clamped to 1..WINDOW_MAX), built as a sorted chain of cells with an age per cell.
//
//   channel    dir  handshake       payload
//   in_ch      in   valid/ready     sample, end_of_stream
//   out_ch     out  valid/ready     median
//   cfg        in   cfg_we          cfg_wdata (window size)
//
// A sample with no result is handled in the idle state alone. One with a
// result then passes the scan state, where the rank token walks the chain
// one cell per cycle to the median cell (position 0 to WINDOW_MAX-1), and
// the push state. Reset clears the cell valid bits at once (no clearing pass).
// A held output result lets the next sample in; its result waits in push.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  swm_in_if.sink                            in_ch,
  swm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (CW > swm_pkg::CFG_WIDTH) ? CW : swm_pkg::CFG_WIDTH;
  localparam logic [CW-1:0] WM_C = CW'(WINDOW_MAX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                      state;
  logic [CW-1:0]                   fill;
  logic [swm_pkg::CFG_WIDTH-1:0]   window_size;
  logic                            out_valid;
  logic [SAMPLE_WIDTH-1:0]         median;
  logic [SAMPLE_WIDTH-1:0]         found;
  logic                            eos;

  logic [KW-1:0]                   ws_x;
  logic [CW-1:0]                   k;
  logic [CW-1:0]                   m;
  logic                            accept;
  logic [CW-1:0]                   fill_sat;
  logic                            has_res;
  logic                            ins;
  logic                            clr;
  logic                            tok0;
  logic                            push_go;
  logic                            del_exists;
  logic [SAMPLE_WIDTH-1:0]         del_val;
  logic [SAMPLE_WIDTH-1:0]         hit_val;
  logic                            hit_any;

  swm_pkg::link_t                  lnk      [WINDOW_MAX];
  swm_pkg::link_t                  lnk_left [WINDOW_MAX];
  swm_pkg::link_t                  lnk_right[WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]         vals     [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]         val_left [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]         val_right[WINDOW_MAX];
  logic [AW-1:0]                   ages     [WINDOW_MAX];
  logic [AW-1:0]                   age_left [WINDOW_MAX];
  logic [AW-1:0]                   age_right[WINDOW_MAX];
  logic                            tok_in   [WINDOW_MAX];
  logic                            tok_out  [WINDOW_MAX];
  logic [CW-1:0]                   cnt_in   [WINDOW_MAX];
  logic [CW-1:0]                   cnt_out  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]           hit_vec;
  logic [WINDOW_MAX-1:0]           valid_vec;

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    ws_x = KW'(window_size);
    if (ws_x == '0) begin
      k = CW'(1);
    end else if (ws_x > KW'(WINDOW_MAX)) begin
      k = WM_C;
    end else begin
      k = CW'(ws_x);
    end
  end

  assign m = (k - 1'b1) >> 1;

  assign accept     = in_ch.valid && in_ch.ready;
  assign fill_sat   = (fill == WM_C) ? fill : fill + 1'b1;
  assign has_res    = fill_sat >= k;
  assign del_exists = fill == WM_C;
  assign ins        = accept && (has_res || !in_ch.end_of_stream);
  assign push_go    = (state == ST_PUSH) && (!out_valid || out_ch.ready);
  assign clr        = (accept && !has_res && in_ch.end_of_stream) || (push_go && eos);
  assign tok0       = accept && has_res;

  assign in_ch.ready   = state == ST_IDLE;
  assign out_ch.valid  = out_valid;
  assign out_ch.median = median;

  genvar i;
  generate
    for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign lnk_left[i] = swm_pkg::LINK_HEAD;
        assign val_left[i] = '0;
        assign age_left[i] = '0;
        assign tok_in[i]   = tok0;
        assign cnt_in[i]   = '0;
      end else begin : g_link_l
        assign lnk_left[i] = lnk[i-1];
        assign val_left[i] = vals[i-1];
        assign age_left[i] = ages[i-1];
        assign tok_in[i]   = tok_out[i-1];
        assign cnt_in[i]   = cnt_out[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_tail
        assign lnk_right[i] = swm_pkg::LINK_NONE;
        assign val_right[i] = '0;
        assign age_right[i] = '0;
      end else begin : g_link_r
        assign lnk_right[i] = lnk[i+1];
        assign val_right[i] = vals[i+1];
        assign age_right[i] = ages[i+1];
      end

      assign valid_vec[i] = lnk[i].valid;

      swm_cell #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .clr        (clr),
        .ins        (ins),
        .new_val    (in_ch.sample),
        .del_exists (del_exists),
        .del_val    (del_val),
        .k          (k),
        .m          (m),
        .lnk_l      (lnk_left[i]),
        .lnk_r      (lnk_right[i]),
        .val_l      (val_left[i]),
        .val_r      (val_right[i]),
        .age_l      (age_left[i]),
        .age_r      (age_right[i]),
        .lnk_o      (lnk[i]),
        .val_o      (vals[i]),
        .age_o      (ages[i]),
        .tok_in     (tok_in[i]),
        .cnt_in     (cnt_in[i]),
        .tok_out    (tok_out[i]),
        .cnt_out    (cnt_out[i]),
        .hit        (hit_vec[i])
      );
    end
  endgenerate

  always_comb begin
    del_val = '0;
    hit_val = '0;
    for (int n = 0; n < WINDOW_MAX; n++) begin
      if (lnk[n].del) begin
        del_val = del_val | vals[n];
      end
      if (hit_vec[n]) begin
        hit_val = hit_val | vals[n];
      end
    end
  end

  assign hit_any = |hit_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      window_size <= swm_pkg::WINDOW_SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (clr) begin
        fill <= '0;
      end else if (ins) begin
        fill <= fill_sat;
      end
      if (push_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tok0) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_any) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eos <= in_ch.end_of_stream;
    end
    if ((state == ST_SCAN) && hit_any) begin
      found <= hit_val;
    end
    if (push_go) begin
      median <= found;
    end
  end

`ifndef SYNTHESIS
  a_fill_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(fill))
    else $error("cell valid count differs from fill count");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell claims the median rank");

  a_result_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_PUSH)
    else $error("result transaction raised outside the push state");
`endif

endmodule

@@ src/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the sorted sample chain. Holds a value and its age, takes part
// in the insert/remove shift with its neighbors and passes the rank token.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter  int WINDOW_MAX   = 64,
  parameter  int SAMPLE_WIDTH = 32,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  logic                    ins,
  input  logic [SAMPLE_WIDTH-1:0] new_val,
  input  logic                    del_exists,
  input  logic [SAMPLE_WIDTH-1:0] del_val,
  input  logic [CW-1:0]           k,
  input  logic [CW-1:0]           m,
  input  swm_pkg::link_t          lnk_l,
  input  swm_pkg::link_t          lnk_r,
  input  logic [SAMPLE_WIDTH-1:0] val_l,
  input  logic [SAMPLE_WIDTH-1:0] val_r,
  input  logic [AW-1:0]           age_l,
  input  logic [AW-1:0]           age_r,
  output swm_pkg::link_t          lnk_o,
  output logic [SAMPLE_WIDTH-1:0] val_o,
  output logic [AW-1:0]           age_o,
  input  logic                    tok_in,
  input  logic [CW-1:0]           cnt_in,
  output logic                    tok_out,
  output logic [CW-1:0]           cnt_out,
  output logic                    hit
);

  localparam logic [AW-1:0] MAX_AGE = AW'(WINDOW_MAX - 1);

  logic                    valid;
  logic [SAMPLE_WIDTH-1:0] val;
  logic [AW-1:0]           age;
  logic                    tok;
  logic [CW-1:0]           cnt;

  logic                    del;
  logic                    dl;
  logic                    gt;
  logic                    from_self;
  logic                    from_right;
  logic                    from_left;
  logic                    valid_next;
  logic [SAMPLE_WIDTH-1:0] val_next;
  logic [AW-1:0]           age_next;
  logic                    in_window;

  assign del = valid && (age == MAX_AGE);
  assign gt  = valid && ($signed(val) > $signed(new_val));
  assign dl  = del_exists && valid && !del && ($signed(val) >= $signed(del_val));

  assign from_self  = valid && !del && (dl == gt);
  assign from_right = lnk_r.valid && !lnk_r.del && lnk_r.dl && !lnk_r.gt;
  assign from_left  = lnk_l.valid && !lnk_l.del && !lnk_l.dl && lnk_l.gt;

  assign valid_next = del_exists ? valid : (valid || lnk_l.valid);

  always_comb begin
    if (from_self) begin
      val_next = val;
      age_next = age + 1'b1;
    end else if (from_right) begin
      val_next = val_r;
      age_next = age_r + 1'b1;
    end else if (from_left) begin
      val_next = val_l;
      age_next = age_l + 1'b1;
    end else begin
      val_next = new_val;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (clr) begin
        valid <= 1'b0;
      end else if (ins) begin
        valid <= valid_next;
      end
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      val <= val_next;
      age <= age_next;
    end
    cnt <= cnt_in;
  end

  assign in_window = valid && (CW'(age) < k);
  assign hit       = tok && in_window && (cnt == m);
  assign tok_out   = tok && !hit;
  assign cnt_out   = cnt + CW'(in_window);

  assign lnk_o = '{valid: valid, del: del, dl: dl, gt: gt};
  assign val_o = val;
  assign age_o = age;

endmodule

@@ verif/sliding_window_median_core_tb.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_core_tb
// Self-checking testbench for the sliding window median filter. A directed
// run covers sample extremes, ties, even windows, out-of-range window sizes
// and end-of-stream clears. Random phases follow with changing window sizes
// and varying handshake pressure. A scoreboard keeps its own copy of the
// sample history, computes the lower median of each full window and
// compares it with every median transaction.
// ----------------------------------------------------------------------------
module sliding_window_median_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX      = 64;
  localparam int SAMPLE_WIDTH    = 32;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int DRAIN_CYCLES    = WINDOW_MAX + 16;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'h8000_0000;

  class median_tracker;
    logic signed [SAMPLE_WIDTH-1:0]   history[$];
    logic signed [SAMPLE_WIDTH-1:0]   expected_medians[$];
    logic [swm_pkg::CFG_WIDTH-1:0]    window_reg;
    int                               errors;

    function new();
      window_reg = swm_pkg::WINDOW_SIZE_RESET;
      errors     = 0;
    endfunction

    function void set_window(logic [swm_pkg::CFG_WIDTH-1:0] value);
      window_reg = value;
    endfunction

    function int active_k();
      if (window_reg == 0) return 1;
      if (window_reg > WINDOW_MAX) return WINDOW_MAX;
      return int'(window_reg);
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction

    function void take_sample(logic [SAMPLE_WIDTH-1:0] value, logic eos);
      logic signed [SAMPLE_WIDTH-1:0] win[$];
      logic signed [SAMPLE_WIDTH-1:0] tmp;
      int k;
      int i;
      int j;
      k = active_k();
      history.push_back(value);
      if (history.size() > WINDOW_MAX) void'(history.pop_front());
      if (history.size() >= k) begin
        for (i = history.size() - k; i < history.size(); i++) win.push_back(history[i]);
        for (i = 1; i < win.size(); i++) begin
          tmp = win[i];
          j = i;
          while (j > 0 && win[j-1] > tmp) begin
            win[j] = win[j-1];
            j--;
          end
          win[j] = tmp;
        end
        expected_medians.push_back(win[(k - 1) / 2]);
      end
      if (eos) history.delete();
    endfunction

    function void match_median(logic [SAMPLE_WIDTH-1:0] got);
      logic [SAMPLE_WIDTH-1:0] want;
      if (expected_medians.size() == 0) begin
        $error("median: no transaction expected, got %0d", $signed(got));
        errors++;
        return;
      end
      want = expected_medians.pop_front();
      if (want !== got) begin
        $error("median: expected %0d, got %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [swm_pkg::CFG_WIDTH-1:0] cfg_wdata;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int cycle_count;

  median_tracker tracker = new();

  swm_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_ch ();
  swm_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_ch ();

  sliding_window_median_core #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_median_core_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) tracker.match_median(out_ch.median);
  end

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return SAMPLE_WIDTH'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic eos);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= value;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_sample(value, eos);
  endtask

  task automatic rest_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_WIDTH-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_window(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [swm_pkg::CFG_WIDTH-1:0] first_windows[8];
    logic [swm_pkg::CFG_WIDTH-1:0] window;
    int random_sent;
    int phase;
    int k;
    int phase_len;
    int phase_sent;
    int seq_len;
    int i;
    bit closes;
    first_windows = '{7'd127, 7'd64, 7'd1, 7'd65, 7'd2, 7'd5, 7'd0, 7'd8};
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_left           = 0;
    cycle_count         = 0;
    random_sent         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    rest_input();

    write_window(7'd0);
    send_sample(32'd1234, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    rest_input();

    write_window(7'd2);
    send_sample(32'd10, 1'b0);
    send_sample(-32'sd20, 1'b0);
    send_sample(32'd30, 1'b0);
    send_sample(32'd30, 1'b1);
    rest_input();

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase < 8) begin
        window = first_windows[phase];
      end else begin
        case ($urandom_range(0, 24))
          0: window = 7'd0;
          1, 2: window = swm_pkg::CFG_WIDTH'($urandom_range(41, 127));
          3, 4, 5: window = swm_pkg::CFG_WIDTH'($urandom_range(10, 40));
          default: window = swm_pkg::CFG_WIDTH'($urandom_range(1, 9));
        endcase
      end
      write_window(window);
      k = tracker.active_k();
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      if (phase % 8 == 4) hold_left = HOLD_OFF_CYCLES;
      phase_len  = (k > 16) ? 3 * k + 40 : $urandom_range(40, 90);
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        seq_len = $urandom_range(1, 2 * k + 6);
        closes  = ($urandom_range(1, 100) <= 80);
        for (i = 0; i < seq_len; i++) begin
          send_sample(rand_sample(), closes && (i == seq_len - 1));
          phase_sent++;
          random_sent++;
          if (phase % 8 == 5 && phase_sent == phase_len / 2) begin
            rest_input();
            wait_drained();
          end
        end
      end
      rest_input();
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("sliding_window_median_core_tb: clean");
    end else begin
      $display("sliding_window_median_core_tb: errors");
    end
    $finish;
  end

endmodule
